/* src/fpa_pkg.sv */
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types and codes for the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

	localparam logic [3:0] ACT_ADD  = 4'd0;
	localparam logic [3:0] ACT_SUB  = 4'd1;
	localparam logic [3:0] ACT_MUL  = 4'd2;
	localparam logic [3:0] ACT_DIV  = 4'd3;
	localparam logic [3:0] ACT_GT   = 4'd4;
	localparam logic [3:0] ACT_LT   = 4'd5;
	localparam logic [3:0] ACT_GE   = 4'd6;
	localparam logic [3:0] ACT_LE   = 4'd7;
	localparam logic [3:0] ACT_EQ   = 4'd8;
	localparam logic [3:0] ACT_NE   = 4'd9;
	localparam logic [3:0] ACT_MIN  = 4'd10;
	localparam logic [3:0] ACT_MAX  = 4'd11;
	localparam logic [3:0] ACT_INC  = 4'd12;
	localparam logic [3:0] ACT_DEC  = 4'd13;
	localparam logic [3:0] ACT_FINT = 4'd14;
	localparam logic [3:0] ACT_TINT = 4'd15;

	localparam logic [1:0] KIND_SIMPLE = 2'd0;
	localparam logic [1:0] KIND_MUL    = 2'd1;
	localparam logic [1:0] KIND_DIV    = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  action;
		logic [31:0] a;
		logic [31:0] b;
	} entry_t;

endpackage

/* src/fpa_front.sv */
// ----------------------------------------------------------------------------
// fpa_front
// Accepts requests and tags each with the execution unit it needs.
// ----------------------------------------------------------------------------
module fpa_front (
	input  logic                 valid,
	output logic                 ready,
	input  logic [3:0]           action,
	input  logic [31:0]          operand_a,
	input  logic [31:0]          operand_b,
	output logic                 push,
	output fpa_pkg::entry_t      push_entry,
	input  logic                 q_full
);
	always_comb begin
		case (action)
			fpa_pkg::ACT_MUL: push_entry.kind = fpa_pkg::KIND_MUL;
			fpa_pkg::ACT_DIV: push_entry.kind = fpa_pkg::KIND_DIV;
			default:          push_entry.kind = fpa_pkg::KIND_SIMPLE;
		endcase
		push_entry.action = action;
		push_entry.a      = operand_a;
		push_entry.b      = operand_b;
	end

	assign ready = !q_full;
	assign push  = valid && !q_full;
endmodule

/* src/fpa_queue.sv */
// ----------------------------------------------------------------------------
// fpa_queue
// Two-entry request queue between front and back.
// ----------------------------------------------------------------------------
module fpa_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  fpa_pkg::entry_t push_entry,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output fpa_pkg::entry_t head
);
	fpa_pkg::entry_t mem_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;

	assign full       = count_q == 2'd2;
	assign head_valid = count_q != 2'd0;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end
endmodule

/* src/fpa_back.sv */
// ----------------------------------------------------------------------------
// fpa_back
// Execution unit: simple ops, two-step multiply, bit-serial divide.
// ----------------------------------------------------------------------------
module fpa_back #(
	parameter int FRAC_BITS = 8,
	parameter int WORD_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  head_valid,
	input  fpa_pkg::entry_t       head,
	output logic                  pop,
	output logic                  valid,
	input  logic                  ready,
	output logic signed [31:0]    result_value,
	output logic                  compare_true,
	output logic                  divide_by_zero
);
	localparam int W  = WORD_BITS;
	localparam int F  = FRAC_BITS;
	localparam int D  = W + F;
	localparam int CW = $clog2(D + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;

	localparam logic [2*W-1:0] MUL_RND = {{(2*W-F){1'b0}}, {F{1'b1}}};
	localparam logic [W-1:0]   TINT_RND = {{(W-F){1'b0}}, {F{1'b1}}};

	logic [1:0]          st_q;
	logic                out_valid_q;
	logic signed [W-1:0] res_q;
	logic                cmp_q;
	logic                dz_q;

	logic signed [2*W-1:0] prod_s1;

	logic [W-1:0]  rem_q;
	logic [D-1:0]  quo_q;
	logic [W-1:0]  den_q;
	logic          neg_q;
	logic          zero_q;
	logic [CW-1:0] cnt_q;

	logic signed [W-1:0] a_w, b_w;
	logic                out_free;
	logic signed [W-1:0] s_res;
	logic                s_cmp;
	logic [W-1:0]        mag_a, mag_b;
	logic [2*W-1:0]      mul_adj;
	logic signed [2*W-1:0] mul_sh;
	logic [W-1:0]        tint_adj;
	logic [W:0]          rem_sh, diff;
	logic [D-1:0]        quo_signed;
	logic                load_out;
	logic signed [W-1:0] load_res;
	logic                load_cmp, load_dz;

	assign a_w      = $signed(head.a[W-1:0]);
	assign b_w      = $signed(head.b[W-1:0]);
	assign out_free = !out_valid_q || ready;
	assign mag_a    = a_w[W-1] ? W'(-a_w) : W'(a_w);
	assign mag_b    = b_w[W-1] ? W'(-b_w) : W'(b_w);

	always_comb begin
		s_res    = '0;
		s_cmp    = 1'b0;
		tint_adj = W'(a_w) + (a_w[W-1] ? TINT_RND : '0);
		case (head.action)
			fpa_pkg::ACT_ADD:  s_res = a_w + b_w;
			fpa_pkg::ACT_SUB:  s_res = a_w - b_w;
			fpa_pkg::ACT_GT:   s_cmp = a_w > b_w;
			fpa_pkg::ACT_LT:   s_cmp = a_w < b_w;
			fpa_pkg::ACT_GE:   s_cmp = a_w >= b_w;
			fpa_pkg::ACT_LE:   s_cmp = a_w <= b_w;
			fpa_pkg::ACT_EQ:   s_cmp = a_w == b_w;
			fpa_pkg::ACT_NE:   s_cmp = a_w != b_w;
			fpa_pkg::ACT_MIN:  s_res = (a_w > b_w) ? b_w : a_w;
			fpa_pkg::ACT_MAX:  s_res = (a_w > b_w) ? a_w : b_w;
			fpa_pkg::ACT_INC:  s_res = a_w + W'(1);
			fpa_pkg::ACT_DEC:  s_res = a_w - W'(1);
			fpa_pkg::ACT_FINT: s_res = a_w <<< F;
			fpa_pkg::ACT_TINT: s_res = $signed(tint_adj) >>> F;
			default:           s_res = '0;
		endcase
	end

	// truncate toward zero: bias negative products before the shift
	assign mul_adj = prod_s1 + (prod_s1[2*W-1] ? MUL_RND : '0);
	assign mul_sh  = $signed(mul_adj) >>> F;

	assign rem_sh     = {rem_q, quo_q[D-1]};
	assign diff       = rem_sh - {1'b0, den_q};
	assign quo_signed = neg_q ? D'(-quo_q) : quo_q;

	always_comb begin
		pop      = 1'b0;
		load_out = 1'b0;
		load_res = s_res;
		load_cmp = s_cmp;
		load_dz  = 1'b0;
		case (st_q)
			ST_IDLE: begin
				if (head_valid && (head.kind != fpa_pkg::KIND_SIMPLE || out_free)) begin
					pop      = 1'b1;
					load_out = head.kind == fpa_pkg::KIND_SIMPLE;
				end
			end
			ST_MUL: begin
				load_out = out_free;
				load_res = mul_sh[W-1:0];
				load_cmp = 1'b0;
			end
			ST_DIV: begin
				load_out = out_free && cnt_q == '0;
				load_res = zero_q ? '0 : $signed(quo_signed[W-1:0]);
				load_cmp = 1'b0;
				load_dz  = zero_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop && head.kind == fpa_pkg::KIND_MUL) prod_s1 <= a_w * b_w;
		if (pop && head.kind == fpa_pkg::KIND_DIV) begin
			rem_q  <= '0;
			quo_q  <= {mag_a, {F{1'b0}}};
			den_q  <= mag_b;
			neg_q  <= a_w[W-1] ^ b_w[W-1];
			zero_q <= b_w == '0;
		end else if (st_q == ST_DIV && cnt_q != '0) begin
			rem_q <= diff[W] ? rem_sh[W-1:0] : diff[W-1:0];
			quo_q <= {quo_q[D-2:0], !diff[W]};
		end
		if (load_out) begin
			res_q <= load_res;
			cmp_q <= load_cmp;
			dz_q  <= load_dz;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (load_out)   out_valid_q <= 1'b1;
			else if (ready) out_valid_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (pop && head.kind == fpa_pkg::KIND_MUL) st_q <= ST_MUL;
					if (pop && head.kind == fpa_pkg::KIND_DIV) begin
						st_q  <= ST_DIV;
						cnt_q <= CW'(D);
					end
				end
				ST_MUL: if (load_out) st_q <= ST_IDLE;
				ST_DIV: begin
					if (cnt_q != '0) cnt_q <= cnt_q - CW'(1);
					if (load_out) st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign valid          = out_valid_q;
	assign result_value   = 32'(res_q);
	assign compare_true   = cmp_q;
	assign divide_by_zero = dz_q;
endmodule

/* src/fixed_point_alu_unit.sv */
// ----------------------------------------------------------------------------
// fixed_point_alu_unit
// Signed fixed-point ALU with decoupled issue queue and execution unit.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_ready with action, operand_a, operand_b.
// Output channel: out_valid/out_ready with result_value, compare_true and
// divide_by_zero, one result per request, in request order.
// Requests enter a two-entry queue; the execution unit drains it.
// Add, sub, compares, min/max, inc/dec and conversions: one request per cycle,
// back to back unless the output stalls; each leaves the queue, then is registered.
// Multiply: in the execution unit, a product register, then the truncating
// shift into the output register.
// Divide: the restoring divider forms one quotient bit per cycle and takes no
// new request meanwhile; divide by zero still runs every quotient step.
// Reset clears the queue, the sequencer and the output valid.
// A stalled receiver holds the output register; the queue then fills and
// in_ready drops once two requests wait in it.
// ----------------------------------------------------------------------------
module fixed_point_alu_unit #(
	parameter int FRAC_BITS = 8,
	parameter int WORD_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [3:0]         action,
	input  logic signed [31:0] operand_a,
	input  logic signed [31:0] operand_b,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] result_value,
	output logic               compare_true,
	output logic               divide_by_zero
);
	logic            push, q_full, pop, head_valid;
	fpa_pkg::entry_t push_entry, head;

	fpa_front u_front (
		.valid      (in_valid),
		.ready      (in_ready),
		.action     (action),
		.operand_a  (operand_a),
		.operand_b  (operand_b),
		.push       (push),
		.push_entry (push_entry),
		.q_full     (q_full)
	);

	fpa_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	fpa_back #(
		.FRAC_BITS (FRAC_BITS),
		.WORD_BITS (WORD_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_valid     (head_valid),
		.head           (head),
		.pop            (pop),
		.valid          (out_valid),
		.ready          (out_ready),
		.result_value   (result_value),
		.compare_true   (compare_true),
		.divide_by_zero (divide_by_zero)
	);
endmodule
